[rtl/stki_pkg.sv]
// Package for the sorted top-k insertion block: sizes and the link type between cells.
`default_nettype none
package stki_pkg;
	localparam int DEPTH   = 64;
	localparam int TAG_W   = 16;
	localparam int SCORE_W = 32;
	localparam int RANK_W  = 7;

	// Data and compare flag that one cell hands to the cell below it.
	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic        [TAG_W-1:0]   tag;
		logic                      hit;
	} cell_link_t;
endpackage
`default_nettype wire

[rtl/stki_cell.sv]
// One slot of the sorted table: holds an entry, compares it and shifts or loads it.
`default_nettype none
module stki_cell import stki_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      insert,
	input  wire logic signed [SCORE_W-1:0] new_score,
	input  wire logic        [TAG_W-1:0]   new_tag,
	input  wire logic                      last_cell,
	input  wire cell_link_t                up_link,
	output cell_link_t                     down_link,
	output logic                           ins
);
	logic signed [SCORE_W-1:0] score_q;
	logic        [TAG_W-1:0]   tag_q;
	logic                      hit;

	// The slot can take the new item when its own score is not greater; the last slot always can.
	assign hit       = last_cell | ~(score_q > new_score);
	assign ins       = hit & ~up_link.hit;
	assign down_link = '{score: score_q, tag: tag_q, hit: hit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			tag_q   <= '0;
		end else if (insert) begin
			if (up_link.hit) begin
				score_q <= up_link.score;
				tag_q   <= up_link.tag;
			end else if (hit) begin
				score_q <= new_score;
				tag_q   <= new_tag;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/sorted_top_k_insert_top.sv]
// Top level of the sorted top-k insertion block: a chain of table cells and the rank encoder.
`default_nettype none
// Usage:
// The block keeps DEPTH (tag, score) entries sorted by descending score.
// An item (player_tag, score) is accepted at a rising edge where start is
// high and busy is low. busy is always low: the chain of cells updates in
// the cycle of acceptance, so a new item may be offered on every cycle.
// Every cell compares its stored score against the broadcast score at once.
// The first cell whose score is not greater takes the new item, every cell
// below it takes its upper neighbor's entry, and the bottom entry drops out.
// The last cell takes the item when no earlier cell does. Equal scores place
// the new item ahead of the older entry.
// The one-hot insert vector is registered, encoded into the 1-based rank,
// and the rank is shown on rank with done high for exactly one cycle. The
// result passes the insert vector register and then the output register
// behind the rank encoder. Throughput is one item per cycle.
// The receiver cannot stall: each result must be taken in its cycle.
// Reset (arst_n low) clears every score and tag to zero and drops any
// result in flight.
module sorted_top_k_insert_top import stki_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic        [TAG_W-1:0]   player_tag,
	input  wire logic signed [SCORE_W-1:0] score,
	output logic                           done,
	output logic             [RANK_W-1:0]  rank
);
	logic                accept;
	logic [DEPTH-1:0]    ins;
	logic [DEPTH-1:0]    ins_s1;
	logic                valid_s1;
	logic [RANK_W-1:0]   rank_c;
	logic [RANK_W-1:0]   rank_q;
	logic                done_q;
	cell_link_t          link [DEPTH+1];

	// The chain never needs to hold an item off.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// The top cell sees an upper neighbor that never hits.
	assign link[0] = '{score: '0, tag: '0, hit: 1'b0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		stki_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.insert    (accept),
			.new_score (score),
			.new_tag   (player_tag),
			.last_cell (i == DEPTH - 1),
			.up_link   (link[i]),
			.down_link (link[i+1]),
			.ins       (ins[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= ins;
		end
	end

	// Exactly one bit of the registered vector is set, so an OR over the
	// masked slot numbers gives the rank. Ranks 1 to 64 fit the field width.
	always_comb begin
		rank_c = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rank_c = rank_c | (ins_s1[i] ? RANK_W'(i + 1) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rank_q <= rank_c;
		end
	end

	assign done = done_q;
	assign rank = rank_q;

	// An accepted item always leaves exactly one insertion point.
	a_one_slot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot(ins_s1))
		else $error("insert vector is not one-hot");

	// The bottom cell always offers its place.
	a_last_hits: assert property (@(posedge clk) disable iff (!arst_n)
		link[DEPTH].hit)
		else $error("last cell does not hit");

	// The table stays sorted at the top.
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		!(link[2].score > link[1].score))
		else $error("top entries out of order");

	// Every accepted item gives its result after the insert vector and output registers.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result missing for accepted item");
endmodule
`default_nettype wire
